// ----- sv/rfpd_pkg.sv -----
// ----------------------------------------------------------------------------
// rfpd_pkg
// Shared types and constants of the radar frame presence detector: header and
// tail bytes, frame layout, time limits, register indexes and item structs.
// ----------------------------------------------------------------------------
package rfpd_pkg;

    localparam int unsigned HDR_LEN     = 4;
    localparam int unsigned FRAME_BYTES = 30;
    localparam int unsigned TAIL_POS    = FRAME_BYTES - 2;
    localparam int unsigned FILL_W      = 5;

    localparam logic [7:0] HDR_BYTE0   = 8'hAA;
    localparam logic [7:0] HDR_BYTE1   = 8'hFF;
    localparam logic [7:0] HDR_BYTE2   = 8'h03;
    localparam logic [7:0] HDR_BYTE3   = 8'h00;
    localparam logic [7:0] TAIL_BYTE0  = 8'h55;
    localparam logic [7:0] TAIL_BYTE1  = 8'hCC;

    localparam int unsigned RECENT_MS  = 200;
    localparam int unsigned MS_PER_SEC = 1000;
    localparam int unsigned ALIVE_MS   = 3000;

    localparam int unsigned SUB_W      = 10;
    localparam int unsigned DUR_W      = 23;
    localparam logic [DUR_W-1:0] DUR_MAX = '1;

    localparam int unsigned OCC_W      = 16;
    localparam int unsigned EMPTY_W    = 20;
    localparam int unsigned CFG_IDX_W  = 4;
    localparam int unsigned CFG_DATA_W = 20;

    localparam logic [CFG_IDX_W-1:0] CFG_OCCUPIED_AFTER = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] CFG_EMPTY_AFTER    = CFG_IDX_W'(1);

    localparam logic [OCC_W-1:0]   OCC_AFTER_MIN   = OCC_W'(500);
    localparam logic [OCC_W-1:0]   OCC_AFTER_MAX   = OCC_W'(60000);
    localparam logic [OCC_W-1:0]   OCC_AFTER_RST   = OCC_W'(1000);
    localparam logic [EMPTY_W-1:0] EMPTY_AFTER_MIN = EMPTY_W'(3000);
    localparam logic [EMPTY_W-1:0] EMPTY_AFTER_MAX = EMPTY_W'(600000);
    localparam logic [EMPTY_W-1:0] EMPTY_AFTER_RST = EMPTY_W'(15000);

    localparam logic FUNC_BYTE = 1'b0;
    localparam logic FUNC_TICK = 1'b1;

    typedef enum logic [1:0] {
        EV_NONE  = 2'd0,
        EV_START = 2'd1,
        EV_END   = 2'd2
    } event_t;

    typedef struct packed {
        logic       good;
        logic [1:0] targets;
    } frame_info_t;

    typedef struct packed {
        logic             is_occupied;
        event_t           event_res;
        logic [DUR_W-1:0] duration_sec;
        logic [1:0]       target_count;
        logic             radar_alive;
        logic             frame_ok;
    } out_item_t;

    function automatic logic [7:0] hdr_byte(input logic [1:0] idx);
        logic [7:0] b;
        unique case (idx)
            2'd0: b = HDR_BYTE0;
            2'd1: b = HDR_BYTE1;
            2'd2: b = HDR_BYTE2;
            2'd3: b = HDR_BYTE3;
            default: b = HDR_BYTE0;
        endcase
        return b;
    endfunction

endpackage

// ----- sv/rfpd_frame_sync.sv -----
// ----------------------------------------------------------------------------
// rfpd_frame_sync
// Header hunt, frame collection, slot occupancy marks and tail check for the
// received radar bytes.
// ----------------------------------------------------------------------------
module rfpd_frame_sync
    import rfpd_pkg::*;
#(
    parameter int unsigned TARGET_SLOTS = 3
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        byte_en,
    input  logic [7:0]  rx_byte,
    output frame_info_t frame
);

    logic [FILL_W-1:0]       fill_reg, fill_next;
    logic [TARGET_SLOTS-1:0] slot_reg, slot_next;
    logic [7:0]              tail_reg, tail_next;
    logic [FILL_W-1:0]       rel;
    logic                    good;
    logic [1:0]              cnt;

    always_comb begin
        fill_next = fill_reg;
        slot_next = slot_reg;
        tail_next = tail_reg;
        good      = 1'b0;
        rel       = fill_reg - FILL_W'(HDR_LEN);
        if (fill_reg < FILL_W'(HDR_LEN)) begin
            if (rx_byte == hdr_byte(fill_reg[1:0])) begin
                fill_next = fill_reg + FILL_W'(1);
                if (fill_reg == FILL_W'(HDR_LEN - 1)) begin
                    slot_next = '0;
                end
            end else begin
                fill_next = (rx_byte == HDR_BYTE0) ? FILL_W'(1) : FILL_W'(0);
            end
        end else begin
            if (fill_reg < FILL_W'(TAIL_POS) && !rel[2] && rx_byte != 8'h00) begin
                for (int i = 0; i < TARGET_SLOTS; i++) begin
                    if (rel[4:3] == 2'(i)) begin
                        slot_next[i] = 1'b1;
                    end
                end
            end
            if (fill_reg == FILL_W'(TAIL_POS)) begin
                tail_next = rx_byte;
            end
            if (fill_reg < FILL_W'(FRAME_BYTES - 1)) begin
                fill_next = fill_reg + FILL_W'(1);
            end else begin
                fill_next = '0;
                good      = (tail_reg == TAIL_BYTE0) && (rx_byte == TAIL_BYTE1);
            end
        end
    end

    always_comb begin
        cnt = 2'd0;
        for (int i = 0; i < TARGET_SLOTS; i++) begin
            cnt = cnt + 2'(slot_reg[i]);
        end
    end

    assign frame.good    = good;
    assign frame.targets = cnt;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fill_reg <= '0;
            slot_reg <= '0;
            tail_reg <= '0;
        end else if (byte_en) begin
            fill_reg <= fill_next;
            slot_reg <= slot_next;
            tail_reg <= tail_next;
        end
    end

endmodule

// ----- sv/rfpd_presence.sv -----
// ----------------------------------------------------------------------------
// rfpd_presence
// Millisecond time base, frame time stamps, occupied/empty hysteresis and the
// running occupied duration in seconds.
// ----------------------------------------------------------------------------
module rfpd_presence
    import rfpd_pkg::*;
#(
    parameter int unsigned TIME_BITS = 32
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               item_en,
    input  logic               func,
    input  frame_info_t        frame,
    input  logic [OCC_W-1:0]   occ_after,
    input  logic [EMPTY_W-1:0] empty_after,
    output out_item_t          result
);

    logic [TIME_BITS-1:0] time_reg;
    logic [TIME_BITS-1:0] time_inc_reg;
    logic [TIME_BITS-1:0] pstamp_reg;
    logic [TIME_BITS-1:0] astamp_reg;
    logic [TIME_BITS-1:0] fstamp_reg;
    logic                 pseen_reg;
    logic                 aseen_reg;
    logic                 occ_reg;
    logic [1:0]           targets_reg;
    logic [TIME_BITS-1:0] el_reg, el_next;
    logic [SUB_W-1:0]     sub_reg, sub_next;
    logic [DUR_W-1:0]     sec_reg, sec_next;

    logic                 is_tick;
    logic                 byte_good;
    logic [TIME_BITS-1:0] t_next;
    logic [TIME_BITS-1:0] since_p;
    logic [TIME_BITS-1:0] since_a;
    logic [TIME_BITS-1:0] since_f;
    logic                 go_occ;
    logic                 go_empty;

    assign is_tick   = (func == FUNC_TICK);
    assign byte_good = !is_tick && frame.good;
    assign t_next    = is_tick ? time_inc_reg : time_reg;
    assign since_p   = time_inc_reg - pstamp_reg;
    assign since_a   = time_inc_reg - astamp_reg;
    assign since_f   = t_next - fstamp_reg;

    assign go_occ = !occ_reg && pseen_reg && (since_p < TIME_BITS'(RECENT_MS))
                  && (!aseen_reg || since_a >= TIME_BITS'(occ_after));
    assign go_empty = occ_reg && aseen_reg && (since_a < TIME_BITS'(RECENT_MS))
                    && (!pseen_reg || since_p >= TIME_BITS'(empty_after));

    // elapsed ms, ms within the second and whole seconds since occupied
    always_comb begin
        if (el_reg == '1) begin
            el_next  = '0;
            sub_next = '0;
            sec_next = '0;
        end else begin
            el_next = el_reg + TIME_BITS'(1);
            if (sub_reg == SUB_W'(MS_PER_SEC - 1)) begin
                sub_next = '0;
                sec_next = (sec_reg == DUR_MAX) ? DUR_MAX : sec_reg + DUR_W'(1);
            end else begin
                sub_next = sub_reg + SUB_W'(1);
                sec_next = sec_reg;
            end
        end
    end

    always_comb begin
        result.is_occupied  = is_tick ? ((occ_reg || go_occ) && !go_empty) : occ_reg;
        result.event_res    = EV_NONE;
        result.duration_sec = '0;
        if (is_tick && go_occ) begin
            result.event_res = EV_START;
        end else if (is_tick && go_empty) begin
            result.event_res    = EV_END;
            result.duration_sec = sec_next;
        end
        result.target_count = byte_good ? frame.targets : targets_reg;
        result.radar_alive  = byte_good
                            || ((pseen_reg || aseen_reg) && since_f < TIME_BITS'(ALIVE_MS));
        result.frame_ok     = byte_good;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            time_reg     <= '0;
            time_inc_reg <= TIME_BITS'(1);
            pstamp_reg   <= '0;
            astamp_reg   <= '0;
            fstamp_reg   <= '0;
            pseen_reg    <= 1'b0;
            aseen_reg    <= 1'b0;
            occ_reg      <= 1'b0;
            targets_reg  <= '0;
            el_reg       <= '0;
            sub_reg      <= '0;
            sec_reg      <= '0;
        end else if (item_en) begin
            if (is_tick) begin
                time_reg     <= time_inc_reg;
                time_inc_reg <= time_inc_reg + TIME_BITS'(1);
                if (go_occ) begin
                    occ_reg <= 1'b1;
                    el_reg  <= '0;
                    sub_reg <= '0;
                    sec_reg <= '0;
                end else if (occ_reg) begin
                    el_reg  <= el_next;
                    sub_reg <= sub_next;
                    sec_reg <= sec_next;
                    if (go_empty) begin
                        occ_reg <= 1'b0;
                    end
                end
            end else if (frame.good) begin
                fstamp_reg  <= time_reg;
                targets_reg <= frame.targets;
                if (frame.targets != 2'd0) begin
                    pstamp_reg <= time_reg;
                    pseen_reg  <= 1'b1;
                end else begin
                    astamp_reg <= time_reg;
                    aseen_reg  <= 1'b1;
                end
            end
        end
    end

endmodule

// ----- sv/radar_frame_presence_detector.sv -----
// ----------------------------------------------------------------------------
// radar_frame_presence_detector
// Radar frame synchronizer with occupied/empty hysteresis on millisecond ticks.
//
//   channel  dir  accepted when            carries
//   s_       in   s_tvalid & s_tready      radar byte or ms tick
//   m_       out  m_tvalid & m_tready      presence state, event, frame status
//   cfg_     in   cfg_valid & cfg_ready    threshold register writes
//
// one item per cycle while s_tready is high, result loaded into the output register on acceptance
// frame and hysteresis state update at the accepting edge
// s_tready drops only while a result waits and m_tready is low
// synchronous active-low reset, no startup pass
// ----------------------------------------------------------------------------
module radar_frame_presence_detector
    import rfpd_pkg::*;
#(
    parameter int unsigned TARGET_SLOTS = 3,
    parameter int unsigned TIME_BITS    = 32
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [7:0]            s_tdata,   // rx_byte
    input  logic                  s_tuser,   // func
    output logic                  m_tvalid,
    input  logic                  m_tready,
    // is_occupied, duration_sec, target_count, radar_alive, frame_ok, zero pad
    output logic [31:0]           m_tdata,
    output logic [1:0]            m_tuser,   // event_res
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    logic               accept;
    logic [OCC_W-1:0]   occ_after_reg;
    logic [EMPTY_W-1:0] empty_after_reg;
    frame_info_t        frame;
    out_item_t          result;
    out_item_t          out_reg;
    logic               out_valid_reg;

    assign s_tready  = !out_valid_reg || m_tready;
    assign accept    = s_tvalid && s_tready;
    assign cfg_ready = 1'b1;

    rfpd_frame_sync #(
        .TARGET_SLOTS (TARGET_SLOTS)
    ) u_frame_sync (
        .aclk    (aclk),
        .aresetn (aresetn),
        .byte_en (accept && (s_tuser == FUNC_BYTE)),
        .rx_byte (s_tdata),
        .frame   (frame)
    );

    rfpd_presence #(
        .TIME_BITS (TIME_BITS)
    ) u_presence (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .item_en     (accept),
        .func        (s_tuser),
        .frame       (frame),
        .occ_after   (occ_after_reg),
        .empty_after (empty_after_reg),
        .result      (result)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            occ_after_reg   <= OCC_AFTER_RST;
            empty_after_reg <= EMPTY_AFTER_RST;
        end else if (cfg_valid && cfg_ready) begin
            if (cfg_index == CFG_OCCUPIED_AFTER) begin
                if (cfg_data[OCC_W-1:0] >= OCC_AFTER_MIN
                        && cfg_data[OCC_W-1:0] <= OCC_AFTER_MAX) begin
                    occ_after_reg <= cfg_data[OCC_W-1:0];
                end
            end else if (cfg_index == CFG_EMPTY_AFTER) begin
                if (cfg_data[EMPTY_W-1:0] >= EMPTY_AFTER_MIN
                        && cfg_data[EMPTY_W-1:0] <= EMPTY_AFTER_MAX) begin
                    empty_after_reg <= cfg_data[EMPTY_W-1:0];
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (accept) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            out_reg <= result;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_reg.event_res;
    assign m_tdata  = {4'b0000, out_reg.frame_ok, out_reg.radar_alive,
                       out_reg.target_count, out_reg.duration_sec, out_reg.is_occupied};

endmodule
